/* rtl/spga_pkg.sv */
// ----------------------------------------------------------------------------
// spga_pkg
// Shared types and constants of the sparse patch gather address generator.
// ----------------------------------------------------------------------------
`default_nettype none

package spga_pkg;

  // field widths
  localparam int DIM_W    = 13;
  localparam int WIN_W    = 4;
  localparam int POS_W    = 3;
  localparam int BATCH_W  = 8;
  localparam int OFF_W    = 24;
  localparam int CH_W     = 12;
  localparam int ADDR_W   = 44;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  // internal widths
  localparam int BC_W     = BATCH_W + DIM_W;     // batch * channel_count
  localparam int PLANE_W  = BC_W + 1 + DIM_W;    // (b*cc + ch) * hh
  localparam int ROW_W    = OFF_W + 2;           // signed window row origin
  localparam int COL_W    = 14;                  // signed window col origin
  localparam int IDX_W    = 12;                  // in-map row or col index
  localparam int LIN_W    = PLANE_W + 1;         // plane_base + row
  localparam int CNT_W    = 5;                   // divider step counter

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_CHANNEL_COUNT = 2'd0,
    REG_MAP_HEIGHT    = 2'd1,
    REG_MAP_WIDTH     = 2'd2,
    REG_WINDOW_SIZE   = 2'd3
  } reg_idx_t;

  // reset values of the configuration registers
  localparam logic [DIM_W-1:0] CHANNEL_COUNT_RST = 13'd256;
  localparam logic [DIM_W-1:0] MAP_HEIGHT_RST    = 13'd64;
  localparam logic [DIM_W-1:0] MAP_WIDTH_RST     = 13'd64;
  localparam logic [WIN_W-1:0] WINDOW_SIZE_RST   = 4'd3;

  typedef struct packed {
    logic [DIM_W-1:0] channel_count;
    logic [DIM_W-1:0] map_height;
    logic [DIM_W-1:0] map_width;
    logic [WIN_W-1:0] window_size;
  } cfg_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SETUP,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic latch;      // capture the input transaction, start the divider
    logic plane_en;   // run the plane base multiplier pipeline
    logic setup;      // form window origin, clear window counters
    logic emit;       // load one result into the output register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic window_zero;
    logic div_done;
    logic last_pos;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

/* rtl/spga_regs.sv */
// ----------------------------------------------------------------------------
// spga_regs
// APB configuration registers: channel count, map height, map width, window.
// ----------------------------------------------------------------------------
`default_nettype none

module spga_regs
  import spga_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel_count <= CHANNEL_COUNT_RST;
      cfg.map_height    <= MAP_HEIGHT_RST;
      cfg.map_width     <= MAP_WIDTH_RST;
      cfg.window_size   <= WINDOW_SIZE_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_CHANNEL_COUNT: cfg.channel_count <= pwdata[DIM_W-1:0];
        REG_MAP_HEIGHT:    cfg.map_height    <= pwdata[DIM_W-1:0];
        REG_MAP_WIDTH:     cfg.map_width     <= pwdata[DIM_W-1:0];
        REG_WINDOW_SIZE:   cfg.window_size   <= pwdata[WIN_W-1:0];
        default:           ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_CHANNEL_COUNT: prdata = APB_DW'(cfg.channel_count);
      REG_MAP_HEIGHT:    prdata = APB_DW'(cfg.map_height);
      REG_MAP_WIDTH:     prdata = APB_DW'(cfg.map_width);
      REG_WINDOW_SIZE:   prdata = APB_DW'(cfg.window_size);
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/spga_div.sv */
// ----------------------------------------------------------------------------
// spga_div
// Restoring divider, one quotient bit per cycle, splits the pixel offset
// into row (quotient) and column (remainder).
// ----------------------------------------------------------------------------
`default_nettype none

module spga_div
  import spga_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [OFF_W-1:0] dividend,
  input  wire logic [DIM_W-1:0] divisor,
  output logic      [OFF_W-1:0] quotient,
  output logic      [DIM_W-1:0] remainder,
  output logic                  done
);

  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(OFF_W - 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DIM_W:0]   trial;
  logic [DIM_W+1:0] diff;

  // shift in the next dividend bit and try a subtract
  assign trial = {remainder, quotient[OFF_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == LAST_STEP) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // quotient and remainder registers
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      quotient <= {quotient[OFF_W-2:0], ~diff[DIM_W+1]};
      if (!diff[DIM_W+1]) begin
        remainder <= diff[DIM_W-1:0];
      end else begin
        remainder <= trial[DIM_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/spga_datapath.sv */
// ----------------------------------------------------------------------------
// spga_datapath
// Input capture, offset divider, plane base multipliers, window counters,
// bounds check, address multiplier and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module spga_datapath
  import spga_pkg::*;
#(
  parameter int MAX_WINDOW = 8,
  parameter int MAX_DIM    = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  cfg_t                    cfg,
  input  ctrl_cmd_t               cmd,
  output dp_status_t              status,
  input  wire logic [BATCH_W-1:0] batch_index,
  input  wire logic [OFF_W-1:0]   pixel_offset,
  input  wire logic [CH_W-1:0]    channel,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [ADDR_W-1:0]  feature_address,
  output logic      [POS_W-1:0]   window_row,
  output logic      [POS_W-1:0]   window_col,
  output logic                    is_padding,
  output logic                    last
);

  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);
  localparam logic [WIN_W-1:0] WIN_MAX = WIN_W'(MAX_WINDOW);

  logic [DIM_W-1:0]   cc_sat, hh_sat, ww_sat;
  logic [WIN_W-1:0]   k_sat;
  logic [BATCH_W-1:0] batch_q;
  logic [CH_W-1:0]    channel_q;
  logic [WIN_W-1:0]   k_q;
  logic [1:0]         half;
  logic [POS_W-1:0]   k_last;
  logic [OFF_W-1:0]   quo;
  logic [DIM_W-1:0]   rem;
  logic               div_done;
  logic [BC_W-1:0]    prod_bc;
  logic [PLANE_W-1:0] plane_base;
  logic signed [ROW_W-1:0] start_row;
  logic signed [COL_W-1:0] start_col;
  logic [POS_W-1:0]   row_counter, col_counter;
  logic signed [ROW_W-1:0] fr;
  logic signed [COL_W-1:0] fc;
  logic               pad;
  logic [LIN_W-1:0]   row_lin;
  logic [LIN_W+DIM_W-1:0] addr_prod;
  logic [ADDR_W-1:0]  addr;
  logic               pos_last;

  // saturate configuration
  assign cc_sat = (cfg.channel_count > DIM_MAX) ? DIM_MAX : cfg.channel_count;
  assign hh_sat = (cfg.map_height    > DIM_MAX) ? DIM_MAX : cfg.map_height;
  assign ww_sat = (cfg.map_width     > DIM_MAX) ? DIM_MAX : cfg.map_width;
  assign k_sat  = (cfg.window_size   > WIN_MAX) ? WIN_MAX : cfg.window_size;

  // capture input transaction
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      batch_q   <= batch_index;
      channel_q <= channel;
      k_q       <= k_sat;
    end
  end

  // offset split by map width
  spga_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.latch),
    .dividend  (pixel_offset),
    .divisor   (ww_sat),
    .quotient  (quo),
    .remainder (rem),
    .done      (div_done)
  );

  // plane base ((batch * cc) + channel) * hh, two registered products
  always_ff @(posedge clk) begin
    if (cmd.plane_en) begin
      prod_bc    <= batch_q * cc_sat;
      plane_base <= PLANE_W'(({1'b0, prod_bc} + (BC_W + 1)'(channel_q)) * hh_sat);
    end
  end

  assign half   = 2'((k_q - 1'b1) >> 1);
  assign k_last = POS_W'(k_q - 1'b1);

  // window origin; zero width means row and column zero
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      if (ww_sat == '0) begin
        start_row <= -$signed(ROW_W'(half));
        start_col <= -$signed(COL_W'(half));
      end else begin
        start_row <= $signed(ROW_W'(quo)) - $signed(ROW_W'(half));
        start_col <= $signed(COL_W'(rem[IDX_W-1:0])) - $signed(COL_W'(half));
      end
    end
  end

  // window position counters, row-major
  assign pos_last = (row_counter == k_last) && (col_counter == k_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter <= '0;
      col_counter <= '0;
    end else if (cmd.setup) begin
      row_counter <= '0;
      col_counter <= '0;
    end else if (cmd.emit && !pos_last) begin
      if (col_counter == k_last) begin
        col_counter <= '0;
        row_counter <= row_counter + 1'b1;
      end else begin
        col_counter <= col_counter + 1'b1;
      end
    end
  end

  // bounds check of the current position
  assign fr  = start_row + $signed(ROW_W'(row_counter));
  assign fc  = start_col + $signed(COL_W'(col_counter));
  assign pad = fr[ROW_W-1] || (fr >= $signed(ROW_W'(hh_sat)))
            || fc[COL_W-1] || (fc >= $signed(COL_W'(ww_sat)));

  // address ((plane_base + row) * ww + col) mod 2^44
  assign row_lin   = LIN_W'(plane_base) + LIN_W'(fr[IDX_W-1:0]);
  assign addr_prod = row_lin * ww_sat;
  assign addr      = ADDR_W'(addr_prod) + ADDR_W'(fc[IDX_W-1:0]);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      feature_address <= pad ? '0 : addr;
      window_row      <= row_counter;
      window_col      <= col_counter;
      is_padding      <= pad;
      last            <= pos_last;
    end
  end

  assign status.window_zero = (cfg.window_size == '0);
  assign status.div_done    = div_done;
  assign status.last_pos    = pos_last;
  assign status.out_free    = !out_valid || out_ready;

endmodule

`default_nettype wire

/* rtl/spga_ctrl.sv */
// ----------------------------------------------------------------------------
// spga_ctrl
// Sequencer: accept, divide, set up the window, emit one result per cycle while the output is free.
// ----------------------------------------------------------------------------
`default_nettype none

module spga_ctrl
  import spga_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  dp_status_t status,
  output ctrl_cmd_t cmd
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        // a zero window takes the transaction and gives no result
        if (in_valid && !status.window_zero) begin
          cmd.latch  = 1'b1;
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd.plane_en = 1'b1;
        if (status.div_done) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.last_pos) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/sparse_patch_gather_address_top.sv */
// ----------------------------------------------------------------------------
// sparse_patch_gather_address_top
// Gather address generator for square patches centered on sparse points.
// ----------------------------------------------------------------------------
// Each input transaction names a batch image, a flat pixel offset and a
// channel; the block emits k * k results, k being window_size capped at
// MAX_WINDOW, in row-major order, each the flat feature address of one
// window position or a padding flag with address zero. An item passes
// through the one-bit-per-cycle divider that splits the offset by
// map_width, a setup state that forms the window origin, the emit state
// with one result per cycle while the output is free, and the idle state
// in which the next input is taken. The next input is taken in the cycle
// after the last result of the previous one enters the output register.
// A window size of zero takes the input and gives no result.
`default_nettype none

module sparse_patch_gather_address_top
  import spga_pkg::*;
#(
  parameter int MAX_WINDOW = 8,
  parameter int MAX_DIM    = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [APB_AW-1:0]  paddr,
  input  wire logic [APB_DW-1:0]  pwdata,
  output logic      [APB_DW-1:0]  prdata,
  output logic                    pready,
  // sample points
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [BATCH_W-1:0] batch_index,
  input  wire logic [OFF_W-1:0]   pixel_offset,
  input  wire logic [CH_W-1:0]    channel,
  // gather addresses
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [ADDR_W-1:0]  feature_address,
  output logic      [POS_W-1:0]   window_row,
  output logic      [POS_W-1:0]   window_col,
  output logic                    is_padding,
  output logic                    last
);

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // configuration registers
  spga_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer
  spga_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // address datapath
  spga_datapath #(
    .MAX_WINDOW (MAX_WINDOW),
    .MAX_DIM    (MAX_DIM)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .cmd             (cmd),
    .status          (status),
    .batch_index     (batch_index),
    .pixel_offset    (pixel_offset),
    .channel         (channel),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .feature_address (feature_address),
    .window_row      (window_row),
    .window_col      (window_col),
    .is_padding      (is_padding),
    .last            (last)
  );

endmodule

`default_nettype wire

/* rtl/spga_checker.sv */
// ----------------------------------------------------------------------------
// spga_checker
// Port-level checks of the gather address generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module spga_checker
  import spga_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [ADDR_W-1:0] feature_address,
  input wire logic [POS_W-1:0]  window_row,
  input wire logic [POS_W-1:0]  window_col,
  input wire logic              is_padding,
  input wire logic              last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(feature_address)
      && $stable(window_row) && $stable(window_col) && $stable(last))
    else $error("result changed while stalled");

  // padding positions carry a zero address
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_padding |-> feature_address == '0)
    else $error("padding result with nonzero address");

  // the final position sits on the window diagonal corner
  a_last_corner: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> window_row == window_col)
    else $error("last flag off the window corner");

  // a taken result that is not the last and not in column zero keeps the previous row
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last && window_col != '0 |->
      window_row == $past(window_row) || !$past(out_valid))
    else $error("window positions out of order");

  // no sample point is taken while a window is still being emitted
  a_in_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> !(out_valid && !last))
    else $error("sample point taken in the middle of a window");

endmodule

bind sparse_patch_gather_address_top spga_checker u_spga_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .feature_address (feature_address),
  .window_row      (window_row),
  .window_col      (window_col),
  .is_padding      (is_padding),
  .last            (last)
);

`default_nettype wire

/* tb/tb_sparse_patch_gather_address_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sparse_patch_gather_address_top
// Self-checking bench for the sparse patch gather address generator.
// ----------------------------------------------------------------------------
// Sample points go in over a valid/ready channel. Each accepted point is
// expanded by a local predictor into the window of gather addresses it
// should produce. Every output transaction is checked against the oldest
// expected gather. A directed table covers the reset setup, the map corners,
// saturated sizes, zero sizes and the zero and single-position windows.
// Random phases follow, each with its own register setup, mostly using
// in-map points with random content and some fully random noise.
// Both channels stall at random, except during one phase with no stalls.

module tb_sparse_patch_gather_address_top;
  import spga_pkg::*;

  localparam int RUN_LIMIT_NS = 400_000;
  localparam int QUIET_CYCLES = 100;
  localparam int MAX_REPORTS  = 10;
  localparam int PHASE_POINTS = 27;
  localparam int PHASES       = 6;
  localparam int WIN_CAP      = 8;
  localparam int DIM_CAP      = 4096;

  typedef logic [63:0] u64_t;

  // one expected gather result
  typedef struct packed {
    logic [ADDR_W-1:0] feature_address;
    logic [POS_W-1:0]  window_row;
    logic [POS_W-1:0]  window_col;
    logic              is_padding;
    logic              last;
  } gather_t;

  // directed stimulus table row
  typedef enum logic {ROW_CFG, ROW_POINT} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    reg_idx_t          regsel;
    logic [APB_DW-1:0] value;
    logic [BATCH_W-1:0] b;
    logic [OFF_W-1:0]  off;
    logic [CH_W-1:0]   ch;
    logic              pinned;
    logic [ADDR_W-1:0] pin_addr;
    logic              pin_pad;
  } step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [APB_AW-1:0]  paddr   = '0;
  logic [APB_DW-1:0]  pwdata  = '0;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  logic               in_valid     = 1'b0;
  logic               in_ready;
  logic [BATCH_W-1:0] batch_index  = '0;
  logic [OFF_W-1:0]   pixel_offset = '0;
  logic [CH_W-1:0]    channel      = '0;

  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [ADDR_W-1:0]  feature_address;
  logic [POS_W-1:0]   window_row;
  logic [POS_W-1:0]   window_col;
  logic               is_padding;
  logic               last;

  // register mirror used by the predictor
  logic [DIM_W-1:0] cfg_channels = CHANNEL_COUNT_RST;
  logic [DIM_W-1:0] cfg_height   = MAP_HEIGHT_RST;
  logic [DIM_W-1:0] cfg_width    = MAP_WIDTH_RST;
  logic [WIN_W-1:0] cfg_window   = WINDOW_SIZE_RST;

  gather_t expected_gathers[$];
  step_t   plan[$];
  int      fault_count = 0;
  int      stall_pct   = 13;

  sparse_patch_gather_address_top dut (.*);

  always #1 clk = ~clk;

  // run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic u64_t clamp_dim(input logic [DIM_W-1:0] v);
    return (v > DIM_CAP) ? u64_t'(DIM_CAP) : u64_t'(v);
  endfunction

  function automatic void note_fault(input string msg);
    fault_count++;
    if (fault_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // expand one sample point into its window of gather results
  function automatic void predict_window(input logic [BATCH_W-1:0] b,
                                         input logic [OFF_W-1:0] off,
                                         input logic [CH_W-1:0] ch);
    u64_t    cc, hh, ww, k, row, col, base, addr;
    longint  half, r0, c0, fr, fc;
    gather_t g;
    cc = clamp_dim(cfg_channels);
    hh = clamp_dim(cfg_height);
    ww = clamp_dim(cfg_width);
    k  = (cfg_window > WIN_CAP) ? u64_t'(WIN_CAP) : u64_t'(cfg_window);
    if (k == 0) return;
    // zero width leaves the offset unsplit at the origin
    if (ww != 0) begin
      row = u64_t'(off) / ww;
      col = u64_t'(off) % ww;
    end else begin
      row = 0;
      col = 0;
    end
    half = (longint'(k) - 1) / 2;
    r0   = longint'(row) - half;
    c0   = longint'(col) - half;
    base = (u64_t'(b) * cc + u64_t'(ch)) * hh;
    for (int wr = 0; wr < k; wr++) begin
      for (int wc = 0; wc < k; wc++) begin
        fr = r0 + wr;
        fc = c0 + wc;
        g.is_padding = (fr < 0) || (fr >= longint'(hh)) || (fc < 0) || (fc >= longint'(ww));
        addr = (base + u64_t'(fr)) * ww + u64_t'(fc);
        g.feature_address = g.is_padding ? '0 : addr[ADDR_W-1:0];
        g.window_row = POS_W'(wr);
        g.window_col = POS_W'(wc);
        g.last = (wr == k - 1) && (wc == k - 1);
        expected_gathers.push_back(g);
      end
    end
  endfunction

  // table row builders
  function automatic step_t cfg_row(input reg_idx_t idx, input logic [APB_DW-1:0] value);
    step_t s;
    s = '{kind: ROW_CFG, regsel: REG_CHANNEL_COUNT, default: '0};
    s.kind   = ROW_CFG;
    s.regsel = idx;
    s.value  = value;
    return s;
  endfunction

  function automatic step_t pinned_row(input logic [BATCH_W-1:0] b, input logic [OFF_W-1:0] off,
                                       input logic [CH_W-1:0] ch, input logic [ADDR_W-1:0] addr,
                                       input logic pad);
    step_t s;
    s = '{kind: ROW_POINT, regsel: REG_CHANNEL_COUNT, default: '0};
    s.kind     = ROW_POINT;
    s.b        = b;
    s.off      = off;
    s.ch       = ch;
    s.pinned   = 1'b1;
    s.pin_addr = addr;
    s.pin_pad  = pad;
    return s;
  endfunction

  function automatic step_t point_row(input logic [BATCH_W-1:0] b, input logic [OFF_W-1:0] off,
                                      input logic [CH_W-1:0] ch);
    step_t s;
    s = pinned_row(b, off, ch, '0, 1'b0);
    s.pinned = 1'b0;
    return s;
  endfunction

  // pick a row or column index, leaning toward the map border
  function automatic u64_t border_pick(input u64_t span);
    case ($urandom_range(3, 0))
      0: return 0;
      1: return span - 1;
      default: return u64_t'($urandom_range(32'(span - 1), 0));
    endcase
  endfunction

  // apb write: setup cycle, then access cycle
  task automatic write_reg(input reg_idx_t idx, input logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_CHANNEL_COUNT: cfg_channels = value[DIM_W-1:0];
      REG_MAP_HEIGHT:    cfg_height   = value[DIM_W-1:0];
      REG_MAP_WIDTH:     cfg_width    = value[DIM_W-1:0];
      REG_WINDOW_SIZE:   cfg_window   = value[WIN_W-1:0];
      default: ;
    endcase
  endtask

  // hold off until every expected gather is back and the block is quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_gathers.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // send one sample point and record its expected window
  task automatic send_point(input logic [BATCH_W-1:0] b, input logic [OFF_W-1:0] off,
                            input logic [CH_W-1:0] ch, input logic pinned,
                            input logic [ADDR_W-1:0] pin_addr, input logic pin_pad);
    int      head;
    gather_t g;
    // random gap before the transaction
    if ($urandom_range(99, 0) < stall_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < stall_pct);
    end
    in_valid     <= 1'b1;
    batch_index  <= b;
    pixel_offset <= off;
    channel      <= ch;
    do @(posedge clk); while (!in_ready);
    head = expected_gathers.size();
    predict_window(b, off, ch);
    // first position typed in by hand where the table gives it
    if (pinned && expected_gathers.size() > head) begin
      g = expected_gathers[head];
      g.feature_address = pin_addr;
      g.is_padding = pin_pad;
      expected_gathers[head] = g;
    end
  endtask

  // one random phase on the current register setup
  task automatic random_phase(input int points);
    u64_t               cc, hh, ww, row, col;
    logic [BATCH_W-1:0] b;
    logic [OFF_W-1:0]   off;
    logic [CH_W-1:0]    ch;
    cc = clamp_dim(cfg_channels);
    hh = clamp_dim(cfg_height);
    ww = clamp_dim(cfg_width);
    for (int n = 0; n < points; n++) begin
      if ($urandom_range(99, 0) < 20) begin
        // noise over the full field ranges
        b   = BATCH_W'($urandom);
        off = OFF_W'($urandom);
        ch  = CH_W'($urandom);
      end else begin
        b  = BATCH_W'($urandom);
        ch = (cc == 0 || cc > (1 << CH_W)) ? CH_W'($urandom) : CH_W'($urandom_range(32'(cc - 1), 0));
        if (ww == 0 || hh == 0) begin
          off = OFF_W'($urandom_range(255, 0));
        end else begin
          row = border_pick(hh);
          col = border_pick(ww);
          off = OFF_W'(row * ww + col);
        end
      end
      send_point(b, off, ch, 1'b0, '0, 1'b0);
    end
  endtask

  function automatic logic [APB_DW-1:0] pick_dim();
    case ($urandom_range(9, 0))
      0: return 32'h1FFF;
      1: return DIM_CAP;
      2: return 1;
      default: return $urandom_range(24, 1);
    endcase
  endfunction

  // output side stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99, 0) >= stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    gather_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_gathers.size() == 0) begin
        note_fault($sformatf("unexpected gather: addr %0d row %0d col %0d pad %0b last %0b",
                             feature_address, window_row, window_col, is_padding, last));
      end else begin
        want = expected_gathers.pop_front();
        if (feature_address !== want.feature_address || window_row !== want.window_row ||
            window_col !== want.window_col || is_padding !== want.is_padding ||
            last !== want.last) begin
          note_fault($sformatf({"gather mismatch: expected addr %0d row %0d col %0d pad %0b ",
                                "last %0b, got addr %0d row %0d col %0d pad %0b last %0b"},
                               want.feature_address, want.window_row, want.window_col,
                               want.is_padding, want.last, feature_address, window_row,
                               window_col, is_padding, last));
        end
      end
    end
  end

  // main sequence
  initial begin
    // reset setup: 256 channels, 64 x 64 map, 3 x 3 window
    plan.push_back(pinned_row(8'd0, 24'd0, 12'd0, 44'd0, 1'b1));
    plan.push_back(pinned_row(8'd0, 24'd65, 12'd0, 44'd0, 1'b0));
    plan.push_back(pinned_row(8'd1, 24'd65, 12'd2, 44'd1056768, 1'b0));
    plan.push_back(pinned_row(8'd0, 24'd4095, 12'd0, 44'd4030, 1'b0));
    // row beyond the map, channel above channel count
    plan.push_back(pinned_row(8'd255, 24'hFFFFFF, 12'd4095, 44'd0, 1'b1));
    plan.push_back(point_row(8'd3, 24'd63, 12'd300));
    // zero window takes the point and gives nothing
    plan.push_back(cfg_row(REG_WINDOW_SIZE, 32'd0));
    plan.push_back(point_row(8'd5, 24'd100, 12'd7));
    // single position window
    plan.push_back(cfg_row(REG_WINDOW_SIZE, 32'd1));
    plan.push_back(pinned_row(8'd2, 24'd130, 12'd9, 44'd2134146, 1'b0));
    // even window, half-width zero
    plan.push_back(cfg_row(REG_WINDOW_SIZE, 32'd2));
    plan.push_back(pinned_row(8'd0, 24'd0, 12'd0, 44'd0, 1'b0));
    // oversized window saturates to eight
    plan.push_back(cfg_row(REG_WINDOW_SIZE, 32'd15));
    plan.push_back(pinned_row(8'd0, 24'd0, 12'd0, 44'd0, 1'b1));
    plan.push_back(point_row(8'd7, 24'd2000, 12'd100));
    // oversized dimensions saturate to the largest map
    plan.push_back(cfg_row(REG_CHANNEL_COUNT, 32'h1FFF));
    plan.push_back(cfg_row(REG_MAP_HEIGHT, 32'h1FFF));
    plan.push_back(cfg_row(REG_MAP_WIDTH, 32'h1FFF));
    plan.push_back(pinned_row(8'd255, 24'hFFFFFF, 12'd4095, 44'd17592186032124, 1'b0));
    plan.push_back(pinned_row(8'd0, 24'd0, 12'd0, 44'd0, 1'b1));
    // zero width: all padding
    plan.push_back(cfg_row(REG_MAP_WIDTH, 32'd0));
    plan.push_back(pinned_row(8'd9, 24'd12345, 12'd1, 44'd0, 1'b1));
    // zero height: all padding
    plan.push_back(cfg_row(REG_MAP_WIDTH, 32'd4096));
    plan.push_back(cfg_row(REG_MAP_HEIGHT, 32'd0));
    plan.push_back(pinned_row(8'd0, 24'd4097, 12'd0, 44'd0, 1'b1));
    // one pixel map, zero channels
    plan.push_back(cfg_row(REG_MAP_HEIGHT, 32'd1));
    plan.push_back(cfg_row(REG_MAP_WIDTH, 32'd1));
    plan.push_back(cfg_row(REG_CHANNEL_COUNT, 32'd0));
    plan.push_back(cfg_row(REG_WINDOW_SIZE, 32'd3));
    plan.push_back(pinned_row(8'd4, 24'd0, 12'd5, 44'd0, 1'b1));
    plan.push_back(point_row(8'd0, 24'd0, 12'd0));
    // tall single column map, largest window
    plan.push_back(cfg_row(REG_WINDOW_SIZE, 32'd8));
    plan.push_back(cfg_row(REG_MAP_HEIGHT, 32'd4096));
    plan.push_back(point_row(8'd1, 24'd4095, 12'd0));
    plan.push_back(point_row(8'd200, 24'd2048, 12'd4000));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        settle();
        write_reg(plan[i].regsel, plan[i].value);
      end else begin
        send_point(plan[i].b, plan[i].off, plan[i].ch, plan[i].pinned,
                   plan[i].pin_addr, plan[i].pin_pad);
      end
    end

    // random phases, each with a fresh register setup
    for (int p = 0; p < PHASES; p++) begin
      settle();
      if (p == 0) begin
        // default setup with no stalls on either side
        stall_pct = 0;
        write_reg(REG_CHANNEL_COUNT, APB_DW'(CHANNEL_COUNT_RST));
        write_reg(REG_MAP_HEIGHT, APB_DW'(MAP_HEIGHT_RST));
        write_reg(REG_MAP_WIDTH, APB_DW'(MAP_WIDTH_RST));
        write_reg(REG_WINDOW_SIZE, APB_DW'(WINDOW_SIZE_RST));
      end else begin
        stall_pct = 13;
        write_reg(REG_CHANNEL_COUNT, pick_dim());
        write_reg(REG_MAP_HEIGHT, pick_dim());
        write_reg(REG_MAP_WIDTH, pick_dim());
        write_reg(REG_WINDOW_SIZE, (p == 1) ? 32'd8 : $urandom_range(15, 1));
      end
      random_phase(PHASE_POINTS);
    end

    settle();
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/spga_pkg.sv
rtl/spga_regs.sv
rtl/spga_div.sv
rtl/spga_datapath.sv
rtl/spga_ctrl.sv
rtl/sparse_patch_gather_address_top.sv
rtl/spga_checker.sv
tb/tb_sparse_patch_gather_address_top.sv
